[hdl/gmcp_pkg.sv]
// Package for the grid minimum-cost path block: register indexes,
// fixed field widths and the cell position flags shared by the top level and cell unit.
// No dependencies.
package gmcp_pkg;

    // Configuration port
    localparam int CFG_DATA_W = 16;
    localparam int CFG_IDX_W  = 2;

    localparam logic [CFG_IDX_W-1:0] CFG_GRID_COLUMNS = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_GRID_ROWS    = 2'd1;

    // Fixed field widths
    localparam int GRID_COLS_W  = 11;
    localparam int GRID_ROWS_W  = 16;
    localparam int CELL_COST_W  = 16;
    localparam int PATH_TOTAL_W = 32;

    // Wide enough to hold the clamped column count at any depth
    localparam int COLS_CALC_W  = 17;

    // Reset grid size
    localparam int RST_GRID_COLS = 3;
    localparam int RST_GRID_ROWS = 3;

    // Where the current cell sits in the grid
    typedef struct packed {
        logic first_row;
        logic first_col;
        logic last;
    } gmcp_pos_t;

endpackage

[hdl/grid_min_cost_path_top.sv]
// Top level of the grid minimum-cost path block: position counters, config,
// the cell stage and the output register. Depends on gmcp_pkg, gmcp_line_store, gmcp_cell_unit.
//
//  channel | signals                          | direction | item
//  --------+----------------------------------+-----------+----------------------------
//  input   | in_valid, in_stall, cell_cost    | in        | one cell cost, row-major
//  output  | out_valid, out_stall, path_total,| out       | total for that cell, plus
//          | final_cell                       |           | the bottom-right marker
//  config  | cfg_we, cfg_index, cfg_data      | in        | one register write, no wait
//
// One item per cycle sustained while the output is not stalled. An item is accepted into the
// cell stage, where the line store read issued at acceptance returns the upper total in the next
// cycle; the result is then held in the output register.
// The rate is set by the left-total loop: min of three plus a saturating add, all combinational.
// Reset clears the counters, the left and upper-left totals and the pipeline valids;
// the line store is not cleared, since the first row never uses what it reads.
// An output stall holds the output register and the cell stage, and stalls the input.
module grid_min_cost_path_top
    import gmcp_pkg::*;
#(
    parameter int MAX_COLS   = 1024,
    parameter int COST_BITS  = 16,
    parameter int TOTAL_BITS = 32
) (
    input  logic                    clk,
    input  logic                    rst_n,
    // config
    input  logic                    cfg_we,
    input  logic [CFG_IDX_W-1:0]    cfg_index,
    input  logic [CFG_DATA_W-1:0]   cfg_data,
    // input item
    input  logic                    in_valid,
    output logic                    in_stall,
    input  logic [CELL_COST_W-1:0]  cell_cost,
    // result item
    output logic                    out_valid,
    input  logic                    out_stall,
    output logic [PATH_TOTAL_W-1:0] path_total,
    output logic                    final_cell
);

    localparam int CIDX_W = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
    localparam int RST_COLS_M1 = ((MAX_COLS < RST_GRID_COLS) ? MAX_COLS : RST_GRID_COLS) - 1;

    // Effective grid size, minus one
    logic [CIDX_W-1:0]      cols_m1_reg, cols_m1_next;
    logic [GRID_ROWS_W-1:0] rows_m1_reg, rows_m1_next;

    // Position of the next cell to accept
    logic [CIDX_W-1:0]      col_reg, col_next;
    logic [GRID_ROWS_W-1:0] row_reg, row_next;

    // Cell stage
    logic                   s1_valid_reg, s1_valid_next;
    logic [COST_BITS-1:0]   s1_cost_reg;
    logic [CIDX_W-1:0]      s1_col_reg;
    gmcp_pos_t              s1_pos_reg;
    gmcp_pos_t              in_pos;
    logic                   byp_hit_reg;

    // Loop state
    logic [TOTAL_BITS-1:0]  left_total_reg, left_total_next;
    logic [TOTAL_BITS-1:0]  diag_total_reg, diag_total_next;

    // Output register
    logic                   out_valid_reg, out_valid_next;
    logic [TOTAL_BITS-1:0]  out_total_reg;
    logic                   out_final_reg;

    logic                   in_acc;
    logic                   s1_adv;
    logic                   cfg_hit;
    logic [TOTAL_BITS-1:0]  mem_q;
    logic [TOTAL_BITS-1:0]  up_total;
    logic [TOTAL_BITS-1:0]  cell_total;
    logic [COLS_CALC_W-1:0] ncols;

    // ---------------------------------------------------------------
    // Handshake: the cell stage moves on whenever the output register is free
    // ---------------------------------------------------------------
    assign s1_adv   = s1_valid_reg && (!out_valid_reg || !out_stall);
    assign in_stall = s1_valid_reg && !s1_adv;
    assign in_acc   = in_valid && !in_stall;

    // ---------------------------------------------------------------
    // Config decode: clamp columns to 1..MAX_COLS, rows to at least 1
    // ---------------------------------------------------------------
    always_comb
    begin
        cols_m1_next = cols_m1_reg;
        rows_m1_next = rows_m1_reg;
        cfg_hit      = 1'b0;
        ncols = COLS_CALC_W'(cfg_data[GRID_COLS_W-1:0]);
        if (ncols == '0)
        begin
            ncols = COLS_CALC_W'(1);
        end
        if (ncols > COLS_CALC_W'(MAX_COLS))
        begin
            ncols = COLS_CALC_W'(MAX_COLS);
        end
        if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_GRID_COLUMNS:
                begin
                    cols_m1_next = CIDX_W'(ncols - COLS_CALC_W'(1));
                    cfg_hit      = 1'b1;
                end
                CFG_GRID_ROWS:
                begin
                    if (cfg_data[GRID_ROWS_W-1:0] == '0)
                    begin
                        rows_m1_next = '0;
                    end
                    else
                    begin
                        rows_m1_next = cfg_data[GRID_ROWS_W-1:0] - GRID_ROWS_W'(1);
                    end
                    cfg_hit = 1'b1;
                end
                default:
                begin
                    // unknown index: ignore the write
                    cfg_hit = 1'b0;
                end
            endcase
        end
    end

    // ---------------------------------------------------------------
    // Position of the accepted cell and the next position
    // ---------------------------------------------------------------
    always_comb
    begin
        in_pos.first_row = (row_reg == '0);
        in_pos.first_col = (col_reg == '0);
        in_pos.last      = (row_reg == rows_m1_reg) && (col_reg == cols_m1_reg);
        col_next = col_reg;
        row_next = row_reg;
        if (cfg_hit)
        begin
            // any register write restarts the grid
            col_next = '0;
            row_next = '0;
        end
        else if (in_acc)
        begin
            if (col_reg == cols_m1_reg)
            begin
                col_next = '0;
                if (row_reg == rows_m1_reg)
                begin
                    row_next = '0;
                end
                else
                begin
                    row_next = row_reg + GRID_ROWS_W'(1);
                end
            end
            else
            begin
                col_next = col_reg + CIDX_W'(1);
            end
        end
    end

    // ---------------------------------------------------------------
    // Line store: read the upper total at acceptance, write back on advance
    // ---------------------------------------------------------------
    gmcp_line_store #(
        .DEPTH (MAX_COLS),
        .WIDTH (TOTAL_BITS)
    ) u_line_store (
        .clk     (clk),
        .wr_en   (s1_adv),
        .wr_addr (s1_col_reg),
        .wr_data (cell_total),
        .rd_en   (in_acc),
        .rd_addr (col_reg),
        .rd_data (mem_q)
    );

    // With one column the upper cell is the one just written: forward it from
    // the left total, which holds the last total written unless a register write cleared it.
    assign up_total = byp_hit_reg ? left_total_reg : mem_q;

    gmcp_cell_unit #(
        .COST_BITS  (COST_BITS),
        .TOTAL_BITS (TOTAL_BITS)
    ) u_cell_unit (
        .pos   (s1_pos_reg),
        .cost  (s1_cost_reg),
        .up    (up_total),
        .left  (left_total_reg),
        .diag  (diag_total_reg),
        .total (cell_total)
    );

    // ---------------------------------------------------------------
    // Next values of the stage and loop state
    // ---------------------------------------------------------------
    always_comb
    begin
        s1_valid_next   = s1_valid_reg;
        left_total_next = left_total_reg;
        diag_total_next = diag_total_reg;
        out_valid_next  = out_valid_reg;
        if (in_acc)
        begin
            s1_valid_next = 1'b1;
        end
        else if (s1_adv)
        begin
            s1_valid_next = 1'b0;
        end
        if (s1_adv)
        begin
            left_total_next = cell_total;
            diag_total_next = up_total;
            out_valid_next  = 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
        if (cfg_hit)
        begin
            left_total_next = '0;
            diag_total_next = '0;
        end
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cols_m1_reg    <= CIDX_W'(RST_COLS_M1);
            rows_m1_reg    <= GRID_ROWS_W'(RST_GRID_ROWS - 1);
            col_reg        <= '0;
            row_reg        <= '0;
            s1_valid_reg   <= 1'b0;
            out_valid_reg  <= 1'b0;
            left_total_reg <= '0;
            diag_total_reg <= '0;
        end
        else
        begin
            cols_m1_reg    <= cols_m1_next;
            rows_m1_reg    <= rows_m1_next;
            col_reg        <= col_next;
            row_reg        <= row_next;
            s1_valid_reg   <= s1_valid_next;
            out_valid_reg  <= out_valid_next;
            left_total_reg <= left_total_next;
            diag_total_reg <= diag_total_next;
        end
    end

    // Payload: load on accept or advance, hold otherwise
    always_ff @(posedge clk)
    begin
        if (in_acc)
        begin
            s1_cost_reg <= COST_BITS'(cell_cost);
            s1_col_reg  <= col_reg;
            s1_pos_reg  <= in_pos;
            // forward when the item ahead writes the entry read now
            byp_hit_reg <= s1_adv && (s1_col_reg == col_reg);
        end
        if (s1_adv)
        begin
            out_total_reg <= cell_total;
            out_final_reg <= s1_pos_reg.last;
        end
    end

    assign out_valid  = out_valid_reg;
    assign path_total = PATH_TOTAL_W'(out_total_reg);
    assign final_cell = out_final_reg;

endmodule

[hdl/gmcp_line_store.sv]
// Line store for the previous row of path totals: one write port and one
// read port, read data registered. Uses no package items.
module gmcp_line_store #(
    parameter int DEPTH = 1024,
    parameter int WIDTH = 32,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data,
    input  logic             rd_en,
    input  logic [AW-1:0]    rd_addr,
    output logic [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Read returns the old entry when the same address is written in this cycle
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

[hdl/gmcp_cell_unit.sv]
// Cell update: picks the base total (zero, left, upper, or minimum of three)
// and adds the cell cost with saturation. Depends on gmcp_pkg.
module gmcp_cell_unit
    import gmcp_pkg::*;
#(
    parameter int COST_BITS  = 16,
    parameter int TOTAL_BITS = 32
) (
    input  gmcp_pos_t             pos,
    input  logic [COST_BITS-1:0]  cost,
    input  logic [TOTAL_BITS-1:0] up,
    input  logic [TOTAL_BITS-1:0] left,
    input  logic [TOTAL_BITS-1:0] diag,
    output logic [TOTAL_BITS-1:0] total
);

    localparam int SUM_W = ((TOTAL_BITS > COST_BITS) ? TOTAL_BITS : COST_BITS) + 1;

    logic [TOTAL_BITS-1:0] min_ld;
    logic [TOTAL_BITS-1:0] min3;
    logic [TOTAL_BITS-1:0] base;
    logic [SUM_W-1:0]      sum;

    always_comb
    begin
        min_ld = (diag < up) ? diag : up;
        min3   = (min_ld < left) ? min_ld : left;
        priority if (pos.first_row && pos.first_col)
        begin
            base = '0;
        end
        else if (pos.first_row)
        begin
            base = left;
        end
        else if (pos.first_col)
        begin
            base = up;
        end
        else
        begin
            base = min3;
        end
        sum = SUM_W'(base) + SUM_W'(cost);
        // Clamp at the all-ones total on overflow
        if (sum[SUM_W-1:TOTAL_BITS] != '0)
        begin
            total = '1;
        end
        else
        begin
            total = sum[TOTAL_BITS-1:0];
        end
    end

endmodule

[hdl/gmcp_checker.sv]
// Port-level checker for grid_min_cost_path_top, with its bind statement.
// Depends on gmcp_pkg and the top level's port list.
module gmcp_checker
    import gmcp_pkg::*;
(
    input logic                    clk,
    input logic                    rst_n,
    input logic                    in_valid,
    input logic                    in_stall,
    input logic                    out_valid,
    input logic                    out_stall,
    input logic [PATH_TOTAL_W-1:0] path_total,
    input logic                    final_cell
);

    // Hold a stalled result
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_stall) |=> (out_valid && $stable(path_total) && $stable(final_cell)))
        else $error("stalled result item changed");

    // Stall the input only while a result is held up downstream
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> (out_valid && out_stall))
        else $error("input stalled without a blocked result");

    // Every accepted item is followed by a valid result after the cell stage and output register
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |-> ##2 out_valid)
        else $error("accepted item produced no result");

    // No new result appears without an item accepted ahead of it through the cell stage
    a_no_invent: assert property (@(posedge clk) disable iff (!rst_n)
        ($rose(out_valid) && $past(rst_n, 2)) |-> $past(in_valid && !in_stall, 2))
        else $error("result item without an accepted item");

endmodule

bind grid_min_cost_path_top gmcp_checker u_gmcp_checker (.*);
